>>> sv/icf_pkg.sv
// shared types and constants for the constant-fold integer alu
// no dependencies

package icf_pkg;

	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned OP_WIDTH   = 4;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_AND  = 4'd3,
		OP_OR   = 4'd4,
		OP_XOR  = 4'd5,
		OP_SHL  = 4'd6,
		OP_SHR  = 4'd7,
		OP_SAR  = 4'd8,
		OP_ROR  = 4'd9,
		OP_DIV  = 4'd10,
		OP_UDIV = 4'd11,
		OP_SMOD = 4'd12,
		OP_UMOD = 4'd13
	} op_t;

	// control that travels with an item down the pipe
	typedef struct packed {
		logic valid;
		logic ok;
		logic is_div;
		logic want_rem;
		logic neg;
	} ctl_t;

endpackage

>>> sv/icf_req_if.sv
// request channel for the alu: opcode and two operands
// depends on icf_pkg

interface icf_req_if #(
	parameter int unsigned W = icf_pkg::DATA_WIDTH
) ();
	logic                          valid;
	logic                          ready;
	logic [icf_pkg::OP_WIDTH-1:0]  opcode;
	logic [W-1:0]                  operand_a;
	logic [W-1:0]                  operand_b;

	modport source (output valid, output opcode, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input opcode, input operand_a, input operand_b,
		output ready);
endinterface

>>> sv/icf_rsp_if.sv
// response channel for the alu: result word and valid flag
// depends on icf_pkg

interface icf_rsp_if #(
	parameter int unsigned W = icf_pkg::DATA_WIDTH
) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] result_value;
	logic         result_valid;

	modport source (output valid, output result_value, output result_valid, input ready);
	modport sink (input valid, input result_value, input result_valid, output ready);
endinterface

>>> sv/icf_front.sv
// first stage: decode, plain alu ops, multiply, divider operand setup
// depends on icf_pkg

module icf_front #(
	parameter int unsigned W = icf_pkg::DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [icf_pkg::OP_WIDTH-1:0]  opcode,
	input  logic [W-1:0]                  operand_a,
	input  logic [W-1:0]                  operand_b,
	output icf_pkg::ctl_t                 ctl_s1,
	output logic [W-1:0]                  simple_s1,
	output logic [W-1:0]                  dvd_s1,
	output logic [W-1:0]                  dsr_s1
);
	localparam int unsigned SW = $clog2(W);

	icf_pkg::op_t   op;
	icf_pkg::ctl_t  ctl_d;
	logic [W-1:0]   simple_d;
	logic [W-1:0]   dvd_d;
	logic [W-1:0]   dsr_d;
	logic [W-1:0]   neg_a;
	logic [W-1:0]   neg_b;
	logic [2*W-1:0] rot;
	logic [SW-1:0]  amt;
	logic           na;
	logic           nb;
	logic           b_zero;
	logic           ovf;

	always_comb begin
		op       = icf_pkg::op_t'(opcode);
		na       = operand_a[W-1];
		nb       = operand_b[W-1];
		neg_a    = W'(0) - operand_a;
		neg_b    = W'(0) - operand_b;
		b_zero   = (operand_b == '0);
		ovf      = (operand_b == '1) && (operand_a == {1'b1, {(W-1){1'b0}}});
		amt      = operand_b[SW-1:0];
		rot      = {operand_a, operand_a} >> amt;
		simple_d = '0;
		dvd_d    = operand_a;
		dsr_d    = operand_b;
		ctl_d    = '0;
		ctl_d.valid = in_valid;
		ctl_d.ok    = 1'b1;
		unique case (op)
			icf_pkg::OP_ADD: simple_d = operand_a + operand_b;
			icf_pkg::OP_SUB: simple_d = operand_a - operand_b;
			icf_pkg::OP_MUL: simple_d = W'(operand_a * operand_b);
			icf_pkg::OP_AND: simple_d = operand_a & operand_b;
			icf_pkg::OP_OR:  simple_d = operand_a | operand_b;
			icf_pkg::OP_XOR: simple_d = operand_a ^ operand_b;
			icf_pkg::OP_SHL: simple_d = operand_a << operand_b;
			icf_pkg::OP_SHR: simple_d = operand_a >> operand_b;
			icf_pkg::OP_SAR: simple_d = W'($signed(operand_a) >>> operand_b);
			icf_pkg::OP_ROR: simple_d = rot[W-1:0];
			icf_pkg::OP_DIV, icf_pkg::OP_SMOD: begin
				ctl_d.is_div   = 1'b1;
				ctl_d.want_rem = (op == icf_pkg::OP_SMOD);
				ctl_d.ok       = !(b_zero || ovf);
				ctl_d.neg      = (op == icf_pkg::OP_SMOD) ? na : (na ^ nb);
				dvd_d          = na ? neg_a : operand_a;
				dsr_d          = nb ? neg_b : operand_b;
			end
			icf_pkg::OP_UDIV, icf_pkg::OP_UMOD: begin
				ctl_d.is_div   = 1'b1;
				ctl_d.want_rem = (op == icf_pkg::OP_UMOD);
				ctl_d.ok       = !b_zero;
			end
			default: ctl_d.ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			simple_s1 <= simple_d;
			dvd_s1    <= dvd_d;
			dsr_s1    <= dsr_d;
		end
	end
endmodule

>>> sv/icf_div_stage.sv
// one restoring-division stage: one quotient bit per stage
// depends on icf_pkg

module icf_div_stage #(
	parameter int unsigned W = icf_pkg::DATA_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  icf_pkg::ctl_t  ctl_i,
	input  logic [W-1:0]   simple_i,
	input  logic [W-1:0]   rem_i,
	input  logic [W-1:0]   quo_i,
	input  logic [W-1:0]   dsr_i,
	output icf_pkg::ctl_t  ctl_o,
	output logic [W-1:0]   simple_o,
	output logic [W-1:0]   rem_o,
	output logic [W-1:0]   quo_o,
	output logic [W-1:0]   dsr_o
);
	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	always_comb begin
		trial = {rem_i, quo_i[W-1]};
		diff  = trial - {1'b0, dsr_i};
		// borrow out of the trial subtract means the divisor did not fit
		ge    = !diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (adv) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			simple_o <= simple_i;
			rem_o    <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_o    <= {quo_i[W-2:0], ge};
			dsr_o    <= dsr_i;
		end
	end
endmodule

>>> sv/int32_alu_constant_fold_top.sv
// top level of the constant-fold integer alu: front stage, divider pipe, output register
// depends on icf_pkg, icf_req_if, icf_rsp_if, icf_front, icf_div_stage

// Pipelined integer alu. One item (opcode, operand_a, operand_b) enters per
// cycle and one item (result_value, result_valid) leaves per cycle, in order.
// Every item reaches the output register through one decode/alu/multiply
// stage, one restoring-divider stage per quotient bit, and one sign-fix and
// select stage. All operations travel the same depth, so order is kept
// without reordering logic. The whole pipe moves together; it stalls only
// when the output register holds an item that the sink has not taken.
// result_valid is 0, with result_value 0, for divide or modulo by zero,
// signed minimum by minus one, and unused opcodes. DATA_WIDTH is expected
// to be a power of two; rotate uses the low bits of operand_b as the
// amount.

module int32_alu_constant_fold_top #(
	parameter int unsigned DATA_WIDTH = icf_pkg::DATA_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	icf_req_if.sink     req,
	icf_rsp_if.source   rsp
);
	localparam int unsigned W = DATA_WIDTH;

	// whole-pipe advance: free when the output slot is empty or being drained
	logic adv;

	icf_pkg::ctl_t ctl     [0:W];
	logic [W-1:0]  simple  [0:W];
	logic [W-1:0]  rem     [0:W];
	logic [W-1:0]  quo     [0:W];
	logic [W-1:0]  dsr     [0:W];

	logic [W-1:0]  sel;
	logic [W-1:0]  fixed;
	logic          out_valid_q;
	logic [W-1:0]  out_value_q;
	logic          out_ok_q;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;

	// decode, plain ops, multiply and divider operand setup
	icf_front #(.W(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (req.valid),
		.opcode    (req.opcode),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.ctl_s1    (ctl[0]),
		.simple_s1 (simple[0]),
		.dvd_s1    (quo[0]),
		.dsr_s1    (dsr[0])
	);

	// partial remainder starts at zero, dividend shifts out of quo
	assign rem[0] = '0;

	// divider pipe, one quotient bit per stage
	for (genvar k = 0; k < W; k++) begin : g_div
		icf_div_stage #(.W(W)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_i    (ctl[k]),
			.simple_i (simple[k]),
			.rem_i    (rem[k]),
			.quo_i    (quo[k]),
			.dsr_i    (dsr[k]),
			.ctl_o    (ctl[k+1]),
			.simple_o (simple[k+1]),
			.rem_o    (rem[k+1]),
			.quo_o    (quo[k+1]),
			.dsr_o    (dsr[k+1])
		);
	end

	// pick quotient, remainder or plain result, then fix the sign; failed items read as zero
	always_comb begin
		if (ctl[W].is_div) begin
			sel = ctl[W].want_rem ? rem[W] : quo[W];
		end else begin
			sel = simple[W];
		end
		fixed = ctl[W].neg ? (W'(0) - sel) : sel;
		if (!ctl[W].ok) begin
			fixed = '0;
		end
	end

	// output register, parts the sink from the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl[W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q <= fixed;
			out_ok_q    <= ctl[W].ok;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.result_valid = out_ok_q;

`ifndef SYNTHESIS
	// a failed evaluation always reads as zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.result_valid |-> rsp.result_value == '0)
		else $error("failed item carries a nonzero result");

	// the pipe only stalls behind a held output item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready)
		else $error("input stalled with output free");

	// a stalled output item stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_value))
		else $error("output item changed under stall");
`endif
endmodule
